[rtl/mcrt_pkg.sv]
// shared types and constants for the mission chunk reassembly table
// no dependencies
package mcrt_pkg;

    localparam int MaxParts      = 16;
    localparam int MaxChunks     = 64;
    localparam int PayloadBytes  = 4096;
    localparam int MaxChunkBytes = 256;

    localparam int PartW  = 4;
    localparam int CntW   = 5;
    localparam int CtotW  = 7;
    localparam int OffW   = 13;
    localparam int LenW   = 9;
    localparam int SlotW  = 6;

    localparam logic [2:0] MODE_CLEAR    = 3'd0;
    localparam logic [2:0] MODE_BEGIN    = 3'd1;
    localparam logic [2:0] MODE_DECLARE  = 3'd2;
    localparam logic [2:0] MODE_STORE    = 3'd3;
    localparam logic [2:0] MODE_GET_PART = 3'd4;
    localparam logic [2:0] MODE_GET_CHNK = 3'd5;
    localparam logic [2:0] MODE_COMPLETE = 3'd6;
    localparam logic [2:0] MODE_MATCH    = 3'd7;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INVALID    = 3'd1;
    localparam logic [2:0] ST_MISMATCH   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ST_DUPLICATE  = 3'd4;
    localparam logic [2:0] ST_INCOMPLETE = 3'd5;
    localparam logic [2:0] ST_FULL       = 3'd6;

    // one chunk record, as held in a cell
    typedef struct packed {
        logic              valid;
        logic [PartW-1:0]  part;
        logic [CtotW-2:0]  chunk;
        logic [CtotW-1:0]  points;
        logic [OffW-1:0]   offset;
        logic [LenW-1:0]   length;
    } rec_t;

    // command to the record chain
    typedef struct packed {
        logic   clear;
        logic   write;
        rec_t   rec;
    } chain_cmd_t;

endpackage

[rtl/mission_chunk_reassembly_table_unit.sv]
// top level of the mission chunk reassembly table; depends on mcrt_pkg, mcrt_chain
// result registered in the done state after its item is taken; get chunk and store chunk scan first:
// the record ring turns once past the head, and a store then turns on to a free cell
// next item taken the cycle after the result is taken; one item in work at a time
// reset (rst_n low, asynchronous) clears the transfer, the part table and all records
module mission_chunk_reassembly_table_unit
    import mcrt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mission tag, part, chunk, points, byte length, part total, chunk total
    input  logic [127:0] s_axis_tdata,
    // mode
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, found, chunk total, points, payload offset, byte length
    output logic [39:0]  m_axis_tdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;
    localparam logic [1:0] S_TRIM = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [2:0]  mode_reg;
    logic [31:0] tag_reg;
    logic [15:0] part_reg, chunk_reg, points_reg, len_reg, ptot_reg, ctot_reg;
    logic [SlotW:0] cnt_reg, cnt_next;

    logic [31:0] active_tag_reg;
    logic        open_reg;
    logic [CntW-1:0] parts_exp_reg;
    logic [MaxParts-1:0] decl_reg;
    logic [CtotW-1:0] pct_reg [MaxParts];
    logic [CtotW-1:0] stored_reg [MaxParts];
    logic [OffW-1:0] used_reg;

    // scan results
    logic        hit_reg, free_reg;
    rec_t        hit_rec_reg;

    logic        out_valid_reg;
    logic [39:0] out_reg;

    logic        shift;
    chain_cmd_t  cmd;
    rec_t        head;

    mcrt_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (shift),
        .cmd   (cmd),
        .head  (head)
    );

    logic [2:0]  in_mode;
    logic [31:0] in_tag;
    assign in_mode = s_axis_tuser;
    assign in_tag  = s_axis_tdata[31:0];

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    // first free cell seen is at distance free_pos; ring must end with it at head
    logic [SlotW:0] free_pos_reg;
    logic head_match;

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign shift  = (state_reg == S_SCAN) ||
                    ((state_reg == S_TRIM) && (cnt_reg != free_pos_reg));

    // part checks
    logic tag_ok, part_ok;
    logic [PartW-1:0] pidx;
    assign pidx    = part_reg[PartW-1:0];
    assign tag_ok  = open_reg && (active_tag_reg == tag_reg);
    assign part_ok = open_reg && (part_reg < {11'd0, parts_exp_reg}) &&
                     (part_reg < 16'(MaxParts));

    logic [16:0] used_sum;
    assign used_sum = {4'd0, used_reg} + {1'b0, len_reg};

    logic [17:0] pts4;
    assign pts4 = {points_reg, 2'b00};

    // stored chunks are unique and below the part's count, so a full count means complete
    logic complete;
    always_comb
    begin
        complete = open_reg;
        for (int p = 0; p < MaxParts; p++)
        begin
            if (p < int'(parts_exp_reg) && (!decl_reg[p] || stored_reg[p] != pct_reg[p]))
            begin
                complete = 1'b0;
            end
        end
    end

    // result and state update
    logic [2:0]  st;
    logic        fnd;
    logic [6:0]  cto, pco;
    logic [12:0] off;
    logic [8:0]  lno;
    logic        do_wipe, do_begin, do_decl, do_store;
    always_comb
    begin
        st = ST_OK; fnd = 1'b0; cto = '0; pco = '0; off = '0; lno = '0;
        do_wipe = 1'b0; do_begin = 1'b0; do_decl = 1'b0; do_store = 1'b0;
        case (mode_reg)
            MODE_CLEAR:
            begin
                do_wipe = 1'b1;
            end
            MODE_BEGIN:
            begin
                if (ptot_reg == 16'd0 || ptot_reg > 16'(MaxParts))
                    st = ST_INVALID;
                else
                    do_begin = 1'b1;
            end
            MODE_DECLARE:
            begin
                if (ctot_reg > 16'(MaxChunks)) st = ST_INVALID;
                else if (!tag_ok) st = ST_MISMATCH;
                else if (!part_ok) st = ST_NOT_FOUND;
                else if (decl_reg[pidx]) st = ST_DUPLICATE;
                else do_decl = 1'b1;
            end
            MODE_STORE:
            begin
                if (len_reg > 16'(MaxChunkBytes) || {2'b00, len_reg} != pts4)
                    st = ST_INVALID;
                else if (!tag_ok) st = ST_MISMATCH;
                else if (!part_ok) st = ST_NOT_FOUND;
                else if (!decl_reg[pidx]) st = ST_INCOMPLETE;
                else if (chunk_reg >= {9'd0, pct_reg[pidx]}) st = ST_INVALID;
                else if (hit_reg) st = ST_DUPLICATE;
                else if (used_sum > 17'(PayloadBytes)) st = ST_FULL;
                else if (!free_reg) st = ST_FULL;
                else
                begin
                    do_store = 1'b1;
                    off = used_reg;
                    lno = len_reg[LenW-1:0];
                end
            end
            MODE_GET_PART:
            begin
                if (part_ok && decl_reg[pidx])
                begin
                    fnd = 1'b1;
                    cto = pct_reg[pidx];
                end
                else st = ST_NOT_FOUND;
            end
            MODE_GET_CHNK:
            begin
                if (hit_reg)
                begin
                    fnd = 1'b1;
                    pco = hit_rec_reg.points;
                    off = hit_rec_reg.offset;
                    lno = hit_rec_reg.length;
                end
                else st = ST_NOT_FOUND;
            end
            MODE_COMPLETE:
            begin
                fnd = complete;
                if (!complete) st = ST_INCOMPLETE;
            end
            default:
            begin
                if (tag_ok) fnd = 1'b1;
                else st = ST_MISMATCH;
            end
        endcase
    end

    // writes go into the head cell, which the trim left on a free record
    always_comb
    begin
        cmd = '0;
        cmd.clear = (state_reg == S_DONE) && (do_wipe || do_begin);
        cmd.write = (state_reg == S_DONE) && do_store;
        cmd.rec.valid  = 1'b1;
        cmd.rec.part   = pidx;
        cmd.rec.chunk  = chunk_reg[CtotW-2:0];
        cmd.rec.points = points_reg[CtotW-1:0];
        cmd.rec.offset = used_reg;
        cmd.rec.length = len_reg[LenW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    if (in_mode == MODE_STORE || in_mode == MODE_GET_CHNK)
                        state_next = S_SCAN;
                    else
                        state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(MaxChunks - 1))
                begin
                    cnt_next = '0;
                    state_next = (mode_reg == MODE_STORE) ? S_TRIM : S_DONE;
                end
            end
            S_TRIM:
            begin
                if (cnt_reg == free_pos_reg)
                    state_next = S_DONE;
                else
                    cnt_next = cnt_reg + 7'd1;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign head_match = head.valid && head.part == pidx &&
                        part_reg[15:PartW] == '0 && chunk_reg[15:CtotW-1] == '0 &&
                        head.chunk == chunk_reg[CtotW-2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            active_tag_reg <= '0;
            open_reg       <= 1'b0;
            parts_exp_reg  <= '0;
            decl_reg       <= '0;
            used_reg       <= '0;
            for (int p = 0; p < MaxParts; p++) pct_reg[p] <= '0;
            for (int p = 0; p < MaxParts; p++) stored_reg[p] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_DONE)
            begin
                out_valid_reg <= 1'b1;
                if (do_wipe || do_begin)
                begin
                    decl_reg <= '0;
                    used_reg <= '0;
                    for (int p = 0; p < MaxParts; p++) pct_reg[p] <= '0;
                    for (int p = 0; p < MaxParts; p++) stored_reg[p] <= '0;
                    active_tag_reg <= do_begin ? tag_reg : 32'd0;
                    open_reg       <= do_begin;
                    parts_exp_reg  <= do_begin ? ptot_reg[CntW-1:0] : '0;
                end
                if (do_decl)
                begin
                    decl_reg[pidx] <= 1'b1;
                    pct_reg[pidx]  <= ctot_reg[CtotW-1:0];
                end
                if (do_store)
                begin
                    used_reg <= used_sum[OffW-1:0];
                    stored_reg[pidx] <= stored_reg[pidx] + 7'd1;
                end
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= in_mode;
            tag_reg    <= in_tag;
            part_reg   <= s_axis_tdata[47:32];
            chunk_reg  <= s_axis_tdata[63:48];
            points_reg <= s_axis_tdata[79:64];
            len_reg    <= s_axis_tdata[95:80];
            ptot_reg   <= s_axis_tdata[111:96];
            ctot_reg   <= s_axis_tdata[127:112];
            hit_reg    <= 1'b0;
            free_reg   <= 1'b0;
            free_pos_reg <= '0;
        end
        if (state_reg == S_SCAN)
        begin
            if (head_match && !hit_reg)
            begin
                hit_reg     <= 1'b1;
                hit_rec_reg <= head;
            end
            if (!head.valid && !free_reg)
            begin
                free_reg     <= 1'b1;
                free_pos_reg <= cnt_reg;
            end
        end
        if (state_reg == S_DONE)
        begin
            out_reg <= {lno, off, pco, cto, fnd, st};
        end
    end

    tag_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");
    scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_reg < 7'(MaxChunks)))
        else $error("scan overran the ring");
    bytes_cap: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= 13'(PayloadBytes))
        else $error("payload store overrun");

endmodule

[rtl/mcrt_cell.sv]
// one chunk record cell of the rotating record chain
// depends on mcrt_pkg
module mcrt_cell
    import mcrt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic shift,
    input  logic clear,
    input  logic load,
    input  rec_t load_rec,
    input  rec_t prev_rec,
    output rec_t rec
);

    rec_t rec_reg;
    rec_t rec_next;

    always_comb
    begin
        rec_next = rec_reg;
        if (clear)
        begin
            rec_next = '0;
        end
        else if (load)
        begin
            rec_next = load_rec;
        end
        else if (shift)
        begin
            rec_next = prev_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec = rec_reg;

endmodule

[rtl/mcrt_chain.sv]
// ring of record cells; cell 0 is the head seen by the controller
// depends on mcrt_pkg, mcrt_cell
module mcrt_chain
    import mcrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift,
    input  chain_cmd_t cmd,
    output rec_t       head
);

    rec_t recs [MaxChunks];

    for (genvar i = 0; i < MaxChunks; i++)
    begin : g_cell
        mcrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (shift),
            .clear    (cmd.clear),
            .load     (cmd.write && (i == 0)),
            .load_rec (cmd.rec),
            .prev_rec (recs[(i + 1) % MaxChunks]),
            .rec      (recs[i])
        );
    end

    assign head = recs[0];

endmodule

[tb/mission_chunk_reassembly_table_unit_test.sv]
// self-checking testbench for mission_chunk_reassembly_table_unit
// drives command items, predicts every result in the bench, checks them in order
// depends on mcrt_pkg and the unit under test
module mission_chunk_reassembly_table_unit_test;
    import mcrt_pkg::*;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] ctot;
        logic [15:0] ptot;
        logic [15:0] len;
        logic [15:0] points;
        logic [15:0] chunk;
        logic [15:0] part;
        logic [31:0] tag;
    } cmd_t;

    typedef struct packed {
        logic [LenW-1:0]  len;
        logic [OffW-1:0]  off;
        logic [CtotW-1:0] pc;
        logic [CtotW-1:0] ct;
        logic             found;
        logic [2:0]       status;
    } reply_t;

    typedef struct {
        bit        valid;
        bit [15:0] part;
        bit [15:0] chunk;
        bit [15:0] points;
        bit [31:0] offset;
        bit [31:0] length;
    } chunk_entry_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [39:0]  m_axis_tdata;

    mission_chunk_reassembly_table_unit dut (.*);

    // transfer table as the bench sees it
    bit [31:0]    cur_tag;
    bit           cur_open;
    int unsigned  cur_parts;
    bit           declared [MaxParts];
    int unsigned  chunk_cnt [MaxParts];
    chunk_entry_t entries [MaxChunks];
    int unsigned  used_bytes;

    reply_t pending_replies[$];
    int     errors;
    int     tx_idle;
    int     rx_idle;
    int     sent;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic void wipe_table();
        cur_tag = '0;
        cur_open = 1'b0;
        cur_parts = 0;
        used_bytes = 0;
        for (int i = 0; i < MaxParts; i++)
        begin
            declared[i] = 1'b0;
            chunk_cnt[i] = 0;
        end
        for (int i = 0; i < MaxChunks; i++)
            entries[i] = '{default: 0};
    endfunction

    function automatic bit tag_ok(bit [31:0] tag);
        return cur_open && cur_tag == tag;
    endfunction

    function automatic bit part_ok(int unsigned part);
        return cur_open && part < cur_parts && part < MaxParts;
    endfunction

    function automatic int locate_chunk(int unsigned part, int unsigned chunk);
        for (int i = 0; i < MaxChunks; i++)
            if (entries[i].valid && entries[i].part == part && entries[i].chunk == chunk)
                return i;
        return -1;
    endfunction

    function automatic reply_t apply_cmd(cmd_t c);
        reply_t      r;
        int          slot;
        int unsigned len;
        int unsigned pts;
        r = '0;
        r.status = ST_OK;
        len = 32'(c.len);
        pts = 32'(c.points);
        case (c.mode)
            MODE_CLEAR: wipe_table();
            MODE_BEGIN:
                if (c.ptot == 0 || c.ptot > MaxParts)
                    r.status = ST_INVALID;
                else
                begin
                    wipe_table();
                    cur_tag = c.tag;
                    cur_parts = 32'(c.ptot);
                    cur_open = 1'b1;
                end
            MODE_DECLARE:
                if (c.ctot > MaxChunks) r.status = ST_INVALID;
                else if (!tag_ok(c.tag)) r.status = ST_MISMATCH;
                else if (!part_ok(c.part)) r.status = ST_NOT_FOUND;
                else if (declared[c.part]) r.status = ST_DUPLICATE;
                else
                begin
                    chunk_cnt[c.part] = 32'(c.ctot);
                    declared[c.part] = 1'b1;
                end
            MODE_STORE:
                if (len > MaxChunkBytes || len != pts * 4) r.status = ST_INVALID;
                else if (!tag_ok(c.tag)) r.status = ST_MISMATCH;
                else if (!part_ok(c.part)) r.status = ST_NOT_FOUND;
                else if (!declared[c.part]) r.status = ST_INCOMPLETE;
                else if (c.chunk >= chunk_cnt[c.part]) r.status = ST_INVALID;
                else if (locate_chunk(c.part, c.chunk) >= 0) r.status = ST_DUPLICATE;
                else if (used_bytes + len > PayloadBytes) r.status = ST_FULL;
                else
                begin
                    slot = -1;
                    for (int i = 0; i < MaxChunks; i++)
                        if (slot < 0 && !entries[i].valid)
                            slot = i;
                    if (slot < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        entries[slot] = '{1'b1, c.part, c.chunk, c.points, used_bytes, len};
                        r.off = OffW'(used_bytes);
                        r.len = LenW'(len);
                        used_bytes += len;
                    end
                end
            MODE_GET_PART:
                if (part_ok(c.part) && declared[c.part])
                begin
                    r.found = 1'b1;
                    r.ct = CtotW'(chunk_cnt[c.part]);
                end
                else
                    r.status = ST_NOT_FOUND;
            MODE_GET_CHNK:
            begin
                slot = locate_chunk(c.part, c.chunk);
                if (slot >= 0)
                begin
                    r.found = 1'b1;
                    r.pc = CtotW'(entries[slot].points);
                    r.off = OffW'(entries[slot].offset);
                    r.len = LenW'(entries[slot].length);
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            MODE_COMPLETE:
            begin
                r.found = cur_open;
                for (int p = 0; p < cur_parts && p < MaxParts; p++)
                begin
                    if (!declared[p])
                        r.found = 1'b0;
                    for (int k = 0; k < chunk_cnt[p]; k++)
                        if (locate_chunk(p, k) < 0)
                            r.found = 1'b0;
                end
                if (!r.found)
                    r.status = ST_INCOMPLETE;
            end
            default:
                if (tag_ok(c.tag)) r.found = 1'b1;
                else r.status = ST_MISMATCH;
        endcase
        return r;
    endfunction

    function automatic cmd_t mk(logic [2:0] mode, logic [31:0] tag, int part, int chunk,
                                int points, int len, int ptot, int ctot);
        cmd_t c;
        c.mode = mode;
        c.tag = tag;
        c.part = 16'(part);
        c.chunk = 16'(chunk);
        c.points = 16'(points);
        c.len = 16'(len);
        c.ptot = 16'(ptot);
        c.ctot = 16'(ctot);
        return c;
    endfunction

    function automatic cmd_t noise_cmd();
        cmd_t c;
        c = cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        return c;
    endfunction

    task automatic send_item(cmd_t c);
        if (tx_idle > 0 && $urandom_range(99) < tx_idle)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tdata <= {c.ctot, c.ptot, c.len, c.points, c.chunk, c.part, c.tag};
        s_axis_tuser <= c.mode;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_replies.push_back(apply_cmd(c));
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle);

    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_replies.size() == 0)
            begin
                $display("%0t unexpected item: exp none act %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got !== want)
                begin
                    $display("%0t mismatch: exp %h act %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        logic [31:0] t;
        t = 32'hFFFF_FFFF;
        send_item(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(MODE_BEGIN, t, 0, 0, 0, 0, 0, 0));
        send_item(mk(MODE_BEGIN, t, 0, 0, 0, 0, 17, 0));
        send_item(mk(MODE_COMPLETE, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(MODE_BEGIN, t, 0, 0, 0, 0, 16, 0));
        send_item(mk(MODE_DECLARE, t, 0, 0, 0, 0, 0, 65));
        send_item(mk(MODE_DECLARE, 0, 0, 0, 0, 0, 0, 4));
        send_item(mk(MODE_DECLARE, t, 16, 0, 0, 0, 0, 4));
        send_item(mk(MODE_DECLARE, t, 0, 0, 0, 0, 0, 64));
        send_item(mk(MODE_DECLARE, t, 0, 0, 0, 0, 0, 2));
        send_item(mk(MODE_STORE, t, 0, 0, 65, 260, 0, 0));
        send_item(mk(MODE_STORE, t, 0, 0, 2, 4, 0, 0));
        send_item(mk(MODE_STORE, 5, 0, 0, 1, 4, 0, 0));
        send_item(mk(MODE_STORE, t, 16, 0, 1, 4, 0, 0));
        send_item(mk(MODE_STORE, t, 1, 0, 1, 4, 0, 0));
        send_item(mk(MODE_STORE, t, 0, 64, 1, 4, 0, 0));
        send_item(mk(MODE_STORE, t, 0, 63, 64, 256, 0, 0));
        send_item(mk(MODE_STORE, t, 0, 63, 1, 4, 0, 0));
        send_item(mk(MODE_GET_PART, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(MODE_GET_PART, 0, 1, 0, 0, 0, 0, 0));
        send_item(mk(MODE_GET_CHNK, 0, 0, 63, 0, 0, 0, 0));
        send_item(mk(MODE_GET_CHNK, 0, 65535, 65535, 0, 0, 0, 0));
        send_item(mk(MODE_MATCH, t, 0, 0, 0, 0, 0, 0));
        send_item(mk(MODE_MATCH, 0, 0, 0, 0, 0, 0, 0));
        drain();
    endtask

    task automatic test_payload_full();
        send_item(mk(MODE_BEGIN, 32'h1234, 0, 0, 0, 0, 1, 0));
        send_item(mk(MODE_DECLARE, 32'h1234, 0, 0, 0, 0, 0, 20));
        for (int k = 0; k < 17; k++)
            send_item(mk(MODE_STORE, 32'h1234, 0, k, 64, 256, 0, 0));
        send_item(mk(MODE_STORE, 32'h1234, 0, 18, 0, 0, 0, 0));
        drain();
    endtask

    task automatic test_records_full();
        send_item(mk(MODE_BEGIN, 32'h5A5A, 0, 0, 0, 0, 2, 0));
        send_item(mk(MODE_DECLARE, 32'h5A5A, 0, 0, 0, 0, 0, 64));
        send_item(mk(MODE_DECLARE, 32'h5A5A, 1, 0, 0, 0, 0, 1));
        for (int k = 0; k < 64; k++)
            send_item(mk(MODE_STORE, 32'h5A5A, 0, k, 0, 0, 0, 0));
        send_item(mk(MODE_COMPLETE, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(MODE_DECLARE, 32'h5A5A, 1, 0, 0, 0, 0, 1));
        send_item(mk(MODE_STORE, 32'h5A5A, 1, 0, 1, 4, 0, 0));
        send_item(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(MODE_GET_CHNK, 0, 0, 0, 0, 0, 0, 0));
        drain();
    endtask

    // well-formed transfers with random content, plus noise and broken items
    task automatic test_random(int count);
        int stop;
        int np;
        int nc;
        int pts;
        logic [31:0] t;
        stop = sent + count;
        while (sent < stop)
        begin
            if ($urandom_range(9) == 0)
                send_item(noise_cmd());
            t = $urandom;
            np = $urandom_range(1, 4);
            send_item(mk(MODE_BEGIN, t, 0, 0, 0, 0, np, 0));
            for (int p = 0; p < np; p++)
                if ($urandom_range(7) != 0)
                    send_item(mk(MODE_DECLARE, t, p, 0, 0, 0, 0, $urandom_range(0, 3)));
            for (int k = 0; k < $urandom_range(2, 12); k++)
            begin
                pts = $urandom_range(0, 20);
                nc = $urandom_range(0, 3);
                case ($urandom_range(9))
                    0: send_item(mk(MODE_STORE, t, $urandom_range(0, np), nc, pts,
                                    pts * 4 + $urandom_range(0, 1), 0, 0));
                    1: send_item(mk(MODE_GET_PART, 0, $urandom_range(0, np), 0, 0, 0, 0, 0));
                    2: send_item(mk(MODE_GET_CHNK, 0, $urandom_range(0, np), nc, 0, 0, 0, 0));
                    3: send_item(mk(MODE_COMPLETE, 0, 0, 0, 0, 0, 0, 0));
                    4: send_item(mk(MODE_MATCH, ($urandom_range(1) ? t : $urandom), 0, 0,
                                    0, 0, 0, 0));
                    5: send_item(noise_cmd());
                    default: send_item(mk(MODE_STORE, t, $urandom_range(0, np - 1), nc,
                                          pts, pts * 4, 0, 0));
                endcase
            end
            for (int p = 0; p < np; p++)
                for (int c = 0; c < 3; c++)
                    if ($urandom_range(3) == 0)
                        send_item(mk(MODE_STORE, t, p, c, 1, 4, 0, 0));
            send_item(mk(MODE_COMPLETE, 0, 0, 0, 0, 0, 0, 0));
        end
        drain();
    endtask

    initial
    begin
        errors = 0;
        sent = 0;
        tx_idle = 22;
        rx_idle = 60;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        wipe_table();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_payload_full();
        test_records_full();
        test_random(130);
        tx_idle = 60;
        rx_idle = 22;
        test_random(130);
        tx_idle = 0;
        rx_idle = 0;
        test_random(130);
        repeat (100) @(posedge clk);
        if (errors == 0 && pending_replies.size() == 0)
            $display("** mission_chunk_reassembly_table_unit: PASSED **");
        else
        begin
            if (pending_replies.size() != 0)
                $display("%0t missing items: exp %0d act 0", $time, pending_replies.size());
            $display("** mission_chunk_reassembly_table_unit: FAILED **");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("** mission_chunk_reassembly_table_unit: FAILED **");
        $finish;
    end

endmodule
